// ===== hdl/sgmu_pkg.sv =====
`default_nettype none
package sgmu_pkg;

  // Lattice geometry
  localparam int SIDE    = 8;
  localparam int AREA    = SIDE * SIDE;
  localparam int NSITES  = AREA * SIDE;
  localparam int ADDR_W  = $clog2(NSITES);
  localparam int COORD_W = $clog2(SIDE);

  // Field widths
  localparam int SITE_W    = 9;
  localparam int VAL_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Scan: the site itself, then six neighbors
  localparam int NBRS  = 6;
  localparam int CNT_W = 3;

  // Reciprocal constants for site / AREA and site / SIDE
  localparam int PROD_W  = 2 * SITE_W + 2;
  localparam int DIVA_SH = SITE_W + $clog2(AREA);
  localparam int DIVA_M  = (2 ** DIVA_SH + AREA - 1) / AREA;
  localparam int DIVS_SH = SITE_W + $clog2(SIDE);
  localparam int DIVS_M  = (2 ** DIVS_SH + SIDE - 1) / SIDE;

  localparam logic MODE_LOAD = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEPT_DE4  = 2'd0,
    REG_ACCEPT_DE8  = 2'd1,
    REG_ACCEPT_DE12 = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              mode;
    logic [SITE_W-1:0] site_index;
    logic              spin_in;
    logic              bond_in;
    logic [VAL_W-1:0]  random_value;
  } in_item_t;

  typedef struct packed {
    logic [SITE_W-1:0] site_out;
    logic              spin_out;
    logic              flipped;
  } out_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] de4;
    logic [VAL_W-1:0] de8;
    logic [VAL_W-1:0] de12;
  } thresh_t;

  // Lattice word: {spin, bond}
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [1:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage
`default_nettype wire

// ===== hdl/spin_glass_metropolis_update.sv =====
`default_nettype none
// Metropolis single-site update on a periodic 3D spin glass of SIDE^3 sites, each
// holding a spin bit and a bond-sign bit in one single-port-read lattice memory.
// A load item (mode 0) writes the site, hands its result to the output register and
// goes back to idle. An update item (mode 1) splits the index into coordinates,
// streams the site and its six wrapped neighbors through the one lattice read port,
// does the threshold compare and write-back, hands the result to the output register
// and goes back to idle.
// Both stretch while the output register is full and not drained. The output
// register lets the next item start while a result waits. Every item yields exactly
// one result; a site index beyond the lattice returns spin 0 and no flip. Thresholds
// are written over the cfg port (index 0: dE=4, 1: dE=8, 2: dE=12) and should change
// only when idle.
module spin_glass_metropolis_update
  import sgmu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

  thresh_t   thr;
  mem_req_t  mem_req;
  logic [1:0] rd_data;
  logic      seq_idle;
  logic      res_valid;
  out_item_t res;
  logic      res_take;

  assign cfg_ready = 1'b1;
  assign in_ready  = seq_idle;
  assign res_take  = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ACCEPT_DE4:  thr.de4  <= cfg_data;
        REG_ACCEPT_DE8:  thr.de8  <= cfg_data;
        REG_ACCEPT_DE12: thr.de12 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

  sgmu_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && seq_idle),
    .item      (in_data),
    .thr       (thr),
    .ack       (res_take),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res       (res),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  sgmu_lattice u_lattice (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire

// ===== hdl/sgmu_lattice.sv =====
`default_nettype none
module sgmu_lattice
  import sgmu_pkg::*;
(
  input  logic       clk,
  input  mem_req_t   req,
  output logic [1:0] rd_data
);

  logic [1:0] mem [NSITES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/sgmu_seq.sv =====
`default_nettype none
module sgmu_seq
  import sgmu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  in_item_t   item,
  input  thresh_t    thr,
  input  logic       ack,
  output logic       idle,
  output logic       res_valid,
  output out_item_t  res,
  output mem_req_t   mem_req,
  input  logic [1:0] rd_data
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DECIDE = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  localparam logic [CNT_W-1:0] LAST_STEP  = CNT_W'(NBRS + 1);
  localparam logic [CNT_W-1:0] FREE_MAX   = CNT_W'(3);
  localparam logic [CNT_W-1:0] AGREE_DE4  = CNT_W'(4);
  localparam logic [CNT_W-1:0] AGREE_DE8  = CNT_W'(5);

  state_t             state, state_next;
  logic [CNT_W-1:0]   step, step_next;
  logic [CNT_W-1:0]   agree, agree_next;
  logic               own_spin, own_spin_next;
  logic               own_bond, own_bond_next;
  logic [SITE_W-1:0]  site, site_next;
  logic [VAL_W-1:0]   rnd, rnd_next;
  logic [COORD_W-1:0] x, x_next;
  logic [COORD_W-1:0] y, y_next;
  logic [COORD_W-1:0] z, z_next;
  out_item_t          res_next;

  logic [PROD_W-1:0]  prod_a, prod_s;
  logic [SITE_W-1:0]  q_side;
  logic [COORD_W-1:0] xn, yn, zn;
  logic [ADDR_W-1:0]  nbr_addr;
  logic [ADDR_W-1:0]  site_addr;
  logic [VAL_W-1:0]   th;
  logic               accept;
  logic               site_ok;

  function automatic logic [COORD_W-1:0] wrap_dec(input logic [COORD_W-1:0] c);
    logic [COORD_W-1:0] r;
    if (c == '0) r = COORD_W'(SIDE - 1);
    else         r = c - 1'b1;
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] wrap_inc(input logic [COORD_W-1:0] c);
    logic [COORD_W-1:0] r;
    if (c == COORD_W'(SIDE - 1)) r = '0;
    else                         r = c + 1'b1;
    return r;
  endfunction

  // Split the linear index by reciprocal multiplication
  assign prod_a = PROD_W'(site) * PROD_W'(DIVA_M);
  assign prod_s = PROD_W'(site) * PROD_W'(DIVS_M);
  assign q_side = SITE_W'(prod_s >> DIVS_SH);

  assign site_ok   = int'(item.site_index) < NSITES;
  assign site_addr = ADDR_W'(site);

  // Neighbor picked by scan step; step 0 reads the site itself
  always_comb begin
    xn = x;
    yn = y;
    zn = z;
    case (step)
      3'd1:    xn = wrap_dec(x);
      3'd2:    xn = wrap_inc(x);
      3'd3:    yn = wrap_dec(y);
      3'd4:    yn = wrap_inc(y);
      3'd5:    zn = wrap_dec(z);
      3'd6:    zn = wrap_inc(z);
      default: ;
    endcase
  end

  assign nbr_addr = ADDR_W'(int'(xn) * AREA + int'(yn) * SIDE + int'(zn));

  // Shared threshold compare; dE = 4 * agree - 12
  always_comb begin
    case (agree)
      AGREE_DE4: th = thr.de4;
      AGREE_DE8: th = thr.de8;
      default:   th = thr.de12;
    endcase
  end

  assign accept = (agree <= FREE_MAX) || (rnd < th);

  always_comb begin
    state_next    = state;
    step_next     = step;
    agree_next    = agree;
    own_spin_next = own_spin;
    own_bond_next = own_bond;
    site_next     = site;
    rnd_next      = rnd;
    x_next        = x;
    y_next        = y;
    z_next        = z;
    res_next      = res;
    mem_req       = '0;
    mem_req.raddr = nbr_addr;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          site_next         = item.site_index;
          rnd_next          = item.random_value;
          res_next.site_out = item.site_index;
          res_next.spin_out = 1'b0;
          res_next.flipped  = 1'b0;
          if (!site_ok) begin
            state_next = S_DONE;
          end else if (item.mode == MODE_LOAD) begin
            mem_req.we        = 1'b1;
            mem_req.waddr     = ADDR_W'(item.site_index);
            mem_req.wdata     = {item.spin_in, item.bond_in};
            res_next.spin_out = item.spin_in;
            state_next        = S_DONE;
          end else begin
            state_next = S_DECODE;
          end
        end
      end
      S_DECODE: begin
        x_next     = COORD_W'(prod_a >> DIVA_SH);
        y_next     = COORD_W'(q_side - SITE_W'(int'(COORD_W'(prod_a >> DIVA_SH)) * SIDE));
        z_next     = COORD_W'(site - SITE_W'(int'(q_side) * SIDE));
        step_next  = '0;
        agree_next = '0;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        mem_req.raddr = (step == '0) ? site_addr : nbr_addr;
        step_next     = step + 1'b1;
        // Read data is registered and belongs to the previous step's address
        if (step == 3'd1) begin
          own_spin_next = rd_data[1];
          own_bond_next = rd_data[0];
        end else if (step != '0 && ((rd_data[1] ~^ rd_data[0]) == own_spin)) begin
          agree_next = agree + 1'b1;
        end
        if (step == LAST_STEP) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (accept) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = site_addr;
          mem_req.wdata = {~own_spin, own_bond};
        end
        res_next.spin_out = own_spin ^ accept;
        res_next.flipped  = accept;
        state_next        = S_DONE;
      end
      S_DONE: begin
        if (ack) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      agree <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      agree <= agree_next;
    end
  end

  always_ff @(posedge clk) begin
    own_spin <= own_spin_next;
    own_bond <= own_bond_next;
    site     <= site_next;
    rnd      <= rnd_next;
    x        <= x_next;
    y        <= y_next;
    z        <= z_next;
    res      <= res_next;
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  a_decide_after_scan: assert property (@(posedge clk) disable iff (rst)
    state == S_DECIDE |-> $past(state) == S_SCAN && $past(step) == LAST_STEP)
    else $error("decision without a full neighbor scan");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> !mem_req.we)
    else $error("lattice write during scan");

  a_flip_reported: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && mem_req.we) |=> state == S_DONE && res.flipped)
    else $error("flip written but not reported");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !ack) |=> state == S_DONE && $stable(res))
    else $error("pending result lost");

endmodule
`default_nettype wire
